FILE: rtl/core/pgm_pkg.sv
// Shared types and codes for the plain PGM stream parser.
package pgm_pkg;

   localparam int unsigned MAX_DIM_DEF = 4096;
   localparam int unsigned Q_DEPTH_DEF = 4;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] ERR_MAGIC          = 2'd0;
   localparam logic [1:0] ERR_HDR_INCOMPLETE = 2'd1;
   localparam logic [1:0] ERR_HDR_INVALID    = 2'd2;
   localparam logic [1:0] ERR_PIXEL          = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  pixel_value;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [7:0]  max_value;
      logic [1:0]  error_code;
      logic        last;
   } res_type;

   // One parsed byte yields up to two results; r0 goes out first.
   typedef struct packed {
      logic    two;
      res_type r1;
      res_type r0;
   } pair_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

FILE: rtl/core/pgm_front.sv
// Byte classifier and header/pixel parser feeding the result queue.
module pgm_front
   import pgm_pkg::*;
#(
   parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] byte_req,
   input  logic       end_of_input,
   input  q_stat_type q_stat,
   output logic       q_push,
   output pair_type   q_wdata
);

   localparam logic [2:0] PH_MAGIC1 = 3'd0;
   localparam logic [2:0] PH_MAGIC2 = 3'd1;
   localparam logic [2:0] PH_WIDTH  = 3'd2;
   localparam logic [2:0] PH_HEIGHT = 3'd3;
   localparam logic [2:0] PH_MAXV   = 3'd4;
   localparam logic [2:0] PH_PIXELS = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;

   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [15:0] ACC_SAT = 16'hFFFF;
   localparam logic [15:0] DIM_CAP = 16'd8191;

   logic [2:0]  phase_ff, phase_in;
   logic        comment_ff, comment_in;
   logic [15:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        sign_ff, sign_in;
   logic        digit_ff, digit_in;
   logic [12:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic [7:0]  max_ff, max_in;
   logic [12:0] col_ff, col_in;
   logic [12:0] row_ff, row_in;

   logic        accept;
   logic        f_valid, s_valid;
   res_type     f_res, s_res;

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic [12:0] dim_of(input logic [15:0] v, input logic neg);
      if (neg || v == 16'd0 || 32'(v) > 32'(MAX_DIM) || v > DIM_CAP) begin
         return 13'd0;
      end
      return v[12:0];
   endfunction

   function automatic res_type make_err(input logic [1:0] code);
      res_type r;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      r.last       = 1'b1;
      return r;
   endfunction

   function automatic res_type make_hdr(input logic [12:0] w, input logic [12:0] h,
                                        input logic [7:0] m);
      res_type r;
      r              = '0;
      r.kind         = KIND_HEADER;
      r.image_width  = w;
      r.image_height = h;
      r.max_value    = m;
      return r;
   endfunction

   function automatic res_type make_pix(input logic [7:0] p, input logic fin);
      res_type r;
      r             = '0;
      r.kind        = KIND_PIXEL;
      r.pixel_value = p;
      r.last        = fin;
      return r;
   endfunction

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      logic        act, act1, c_dig, c_sp, do_fin, fin, col_end;
      logic [2:0]  ph1;
      logic [1:0]  tok_code;
      logic [7:0]  max_v;
      logic [15:0] acc_base, added;
      logic [19:0] prod;

      phase_in   = phase_ff;
      comment_in = comment_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      sign_in    = sign_ff;
      digit_in   = digit_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      max_in     = max_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      f_valid    = 1'b0;
      f_res      = '0;
      s_valid    = 1'b0;
      s_res      = '0;
      fin        = 1'b0;
      max_v      = 8'd0;

      act     = (phase_ff >= PH_WIDTH) && (phase_ff <= PH_PIXELS);
      c_dig   = is_digit(byte_req);
      c_sp    = is_space(byte_req);
      col_end = ({1'b0, col_ff} + 14'd1) >= {1'b0, width_ff};
      // A number ends on end of input or on the first non-digit outside a comment
      do_fin  = act && digit_ff && (end_of_input || (!comment_ff && !c_dig));
      ph1     = phase_ff;

      if (do_fin) begin
         acc_in   = 16'd0;
         neg_in   = 1'b0;
         sign_in  = 1'b0;
         digit_in = 1'b0;
         case (phase_ff)
            PH_WIDTH: begin
               width_in = dim_of(acc_ff, neg_ff);
               ph1      = PH_HEIGHT;
            end
            PH_HEIGHT: begin
               height_in = dim_of(acc_ff, neg_ff);
               ph1       = PH_MAXV;
            end
            PH_MAXV: begin
               max_v   = (!neg_ff && acc_ff >= 16'd1 && acc_ff <= 16'd255) ?
                         acc_ff[7:0] : 8'd0;
               max_in  = max_v;
               f_valid = 1'b1;
               if (width_ff == 13'd0 || height_ff == 13'd0 || max_v == 8'd0) begin
                  f_res = make_err(ERR_HDR_INVALID);
                  ph1   = PH_DONE;
               end else begin
                  f_res  = make_hdr(width_ff, height_ff, max_v);
                  col_in = 13'd0;
                  row_in = 13'd0;
                  ph1    = PH_PIXELS;
               end
            end
            PH_PIXELS: begin
               f_valid = 1'b1;
               if ((neg_ff && acc_ff != 16'd0) || acc_ff > {8'd0, max_ff}) begin
                  f_res = make_err(ERR_PIXEL);
                  ph1   = PH_DONE;
               end else begin
                  fin   = col_end && (({1'b0, row_ff} + 14'd1) >= {1'b0, height_ff});
                  f_res = make_pix(acc_ff[7:0], fin);
                  if (fin) begin
                     ph1 = PH_DONE;
                  end else if (col_end) begin
                     col_in = 13'd0;
                     row_in = row_ff + 13'd1;
                  end else begin
                     col_in = col_ff + 13'd1;
                  end
               end
            end
            default: ;
         endcase
      end
      phase_in = ph1;

      act1     = (ph1 >= PH_WIDTH) && (ph1 <= PH_PIXELS);
      tok_code = (ph1 == PH_PIXELS) ? ERR_PIXEL : ERR_HDR_INCOMPLETE;
      acc_base = do_fin ? 16'd0 : acc_ff;
      prod     = 20'(acc_base) * 20'd10 + 20'(byte_req[3:0]);
      added    = (prod > 20'(ACC_SAT)) ? ACC_SAT : prod[15:0];

      if (end_of_input) begin
         if (phase_ff == PH_MAGIC1 || phase_ff == PH_MAGIC2) begin
            s_valid = 1'b1;
            s_res   = make_err(ERR_MAGIC);
         end else if (act1) begin
            s_valid = 1'b1;
            s_res   = make_err(tok_code);
         end
         // Restart: the next byte opens a new file
         phase_in   = PH_MAGIC1;
         comment_in = 1'b0;
         acc_in     = 16'd0;
         neg_in     = 1'b0;
         sign_in    = 1'b0;
         digit_in   = 1'b0;
         width_in   = 13'd0;
         height_in  = 13'd0;
         max_in     = 8'd0;
         col_in     = 13'd0;
         row_in     = 13'd0;
      end else begin
         case (phase_ff)
            PH_MAGIC1: begin
               if (c_sp) begin
                  phase_in = PH_MAGIC1;
               end else if (byte_req == CH_P) begin
                  phase_in = PH_MAGIC2;
               end else begin
                  s_valid  = 1'b1;
                  s_res    = make_err(ERR_MAGIC);
                  phase_in = PH_DONE;
               end
            end
            PH_MAGIC2: begin
               if (byte_req == CH_TWO) begin
                  phase_in = PH_WIDTH;
               end else begin
                  s_valid  = 1'b1;
                  s_res    = make_err(ERR_MAGIC);
                  phase_in = PH_DONE;
               end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXV, PH_PIXELS: begin
               if (comment_ff) begin
                  if (byte_req == CH_LF) begin
                     comment_in = 1'b0;
                  end
               end else if (digit_ff && c_dig) begin
                  acc_in = added;
               end else if (!digit_ff && sign_ff) begin
                  if (c_dig) begin
                     acc_in   = added;
                     digit_in = 1'b1;
                  end else begin
                     s_valid  = 1'b1;
                     s_res    = make_err(tok_code);
                     phase_in = PH_DONE;
                  end
               end else if (act1) begin
                  // Examine the byte as the start of the next token
                  if (c_sp) begin
                     comment_in = 1'b0;
                  end else if (byte_req == CH_HASH) begin
                     comment_in = 1'b1;
                  end else if (byte_req == CH_PLUS || byte_req == CH_MINUS) begin
                     sign_in = 1'b1;
                     neg_in  = (byte_req == CH_MINUS);
                  end else if (c_dig) begin
                     acc_in   = added;
                     digit_in = 1'b1;
                  end else begin
                     s_valid  = 1'b1;
                     s_res    = make_err(tok_code);
                     phase_in = PH_DONE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      q_wdata = '0;
      if (f_valid) begin
         q_wdata.r0  = f_res;
         q_wdata.r1  = s_res;
         q_wdata.two = s_valid;
      end else begin
         q_wdata.r0 = s_res;
      end
   end

   assign q_push = accept && (f_valid || s_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC1;
         comment_ff <= 1'b0;
         acc_ff     <= 16'd0;
         neg_ff     <= 1'b0;
         sign_ff    <= 1'b0;
         digit_ff   <= 1'b0;
         width_ff   <= 13'd0;
         height_ff  <= 13'd0;
         max_ff     <= 8'd0;
         col_ff     <= 13'd0;
         row_ff     <= 13'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         comment_ff <= comment_in;
         acc_ff     <= acc_in;
         neg_ff     <= neg_in;
         sign_ff    <= sign_in;
         digit_ff   <= digit_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         max_ff     <= max_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
      end
   end

endmodule

FILE: rtl/core/pgm_queue.sv
// Short queue of result pairs between the parser and the output stage.
module pgm_queue
   import pgm_pkg::*;
#(
   parameter int unsigned DEPTH = Q_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  pair_type   wdata,
   input  logic       pop,
   output pair_type   rdata,
   output q_stat_type stat
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   pair_type      mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rdata      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/pgm_back.sv
// Output stage: takes pairs from the queue and sends their results one by one.
module pgm_back
   import pgm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_stat_type q_stat,
   input  pair_type   q_rdata,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output res_type    rsp_res
);

   pair_type pair_ff, pair_in;
   logic     have_ff, have_in;
   logic     sel_ff, sel_in;
   logic     fire, entry_done;

   assign rsp_tvalid = have_ff;
   assign fire       = have_ff && rsp_tready;
   assign entry_done = !have_ff || (fire && (sel_ff || !pair_ff.two));
   assign q_pop      = entry_done && !q_stat.empty;
   assign rsp_res    = sel_ff ? pair_ff.r1 : pair_ff.r0;

   always_comb begin
      pair_in = pair_ff;
      have_in = have_ff;
      sel_in  = sel_ff;
      if (q_pop) begin
         pair_in = q_rdata;
         have_in = 1'b1;
         sel_in  = 1'b0;
      end else if (entry_done) begin
         have_in = 1'b0;
      end else if (fire) begin
         // advance to the second result of the pair
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         sel_ff  <= 1'b0;
      end else begin
         have_ff <= have_in;
         sel_ff  <= sel_in;
      end
   end

endmodule

FILE: rtl/core/pgm_ascii_stream_parser_top.sv
// Plain PGM text parser: parser front, pair queue and output stage.
// Throughput: one byte per cycle while the queue is not full; a byte that ends a number
//   and then fails emits two results, sent one at a time while the queue absorbs them.
// Path: a result goes into the queue, then into the output stage's pair register, to rsp.
// Reset: synchronous; returns the parser to the magic search and empties the queue.
module pgm_ascii_stream_parser_top
   import pgm_pkg::*;
#(
   parameter int unsigned MAX_DIM = MAX_DIM_DEF,
   parameter int unsigned Q_DEPTH = Q_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] byte_req
   input  logic        req_tlast,  // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] pixel_value, [20:8] image_width, [33:21] image_height,
   // [41:34] max_value, [43:42] error_code, [47:44] zero
   output logic [47:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,  // [1:0] kind
   output logic        rsp_tlast   // last
);

   q_stat_type q_stat;
   pair_type   q_wdata, q_rdata;
   logic       q_push, q_pop;
   res_type    rsp_res;

   pgm_front #(
      .MAX_DIM(MAX_DIM)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .byte_req    (req_tdata),
      .end_of_input(req_tlast),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_wdata     (q_wdata)
   );

   pgm_queue #(
      .DEPTH(Q_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push (q_push),
      .wdata(q_wdata),
      .pop  (q_pop),
      .rdata(q_rdata),
      .stat (q_stat)
   );

   pgm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_res   (rsp_res)
   );

   assign rsp_tdata = {4'd0, rsp_res.error_code, rsp_res.max_value, rsp_res.image_height,
                       rsp_res.image_width, rsp_res.pixel_value};
   assign rsp_tuser = rsp_res.kind;
   assign rsp_tlast = rsp_res.last;

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("result pair pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pair popped from an empty queue");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_ERROR) |-> rsp_tlast)
      else $error("error result without last");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule
